FILE: design/bmch_pkg.sv
// Shared types, register codes and constants for the battery monitor charge hysteresis unit.
package bmch_pkg;

  // Field widths
  localparam int ADC_BITS  = 10;
  localparam int TICK_W    = 32;
  localparam int VOLT_W    = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 3;

  // Defaults handed to the top-level parameters, and the result queue depth
  localparam int SAMPLE_COUNT_DEF = 15;
  localparam int QUEUE_DEPTH_DEF  = 4;
  localparam int OUT_DEPTH        = 2;

  // Measurement arithmetic
  localparam int CAL_SCALE  = 10;
  localparam int VOLT_SHIFT = 13;
  localparam int TRIM_COUNT = 4;
  localparam int CALX_W     = CFG_W + 4;
  localparam int SCALED_W   = ADC_BITS + CALX_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CALIBRATION        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LOWER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_UPPER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_MAINTAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_DISABLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_MIN       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_MAX       = 3'd7;

  // Register reset values
  localparam logic [CALX_W-1:0] CAL_X10_RST  = '0;
  localparam logic [CFG_W-1:0]  LOWER_RST    = 8'd0;
  localparam logic [CFG_W-1:0]  UPPER_RST    = 8'd255;
  localparam logic [CFG_W-1:0]  MAINTAIN_RST = 8'd255;
  localparam logic [CFG_W-1:0]  DISABLE_RST  = 8'd0;
  localparam logic [CFG_W-1:0]  INTERVAL_RST = 8'd7;
  localparam logic [CFG_W-1:0]  EMIN_RST     = 8'd90;
  localparam logic [CFG_W-1:0]  EMAX_RST     = 8'd150;

  // Command codes carried through the queue
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [TICK_W-1:0]   tick_count;
    logic [ADC_BITS-1:0] adc_sample;
  } item_t;

  typedef struct packed {
    logic              sample_request;
    logic [VOLT_W-1:0] voltage;
    logic              out_of_range;
    logic              charge_disable;
    logic              maintain;
    logic              load_disable;
  } result_t;

  typedef struct packed {
    logic              op;
    logic [TICK_W-1:0] arg;
  } cmd_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage

FILE: design/bmch_fifo.sv
// Small register-based first-in first-out queue with push/full and pop/empty sides.
module bmch_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rdata   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: design/bmch_front.sv
// Input stage: takes items, classifies them into tick or sample commands and feeds the queue.
module bmch_front import bmch_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item,
  output logic  full,
  output logic  q_push,
  output cmd_t  q_cmd,
  input  logic  q_full
);

  logic hold_valid;
  cmd_t hold;
  cmd_t classified;
  logic load;

  // Samples ride in the low bits of the argument, ticks use all of it
  always_comb begin
    classified.op  = item.req_type ? OP_SAMPLE : OP_TICK;
    classified.arg = item.req_type ? TICK_W'(item.adc_sample) : item.tick_count;
  end

  assign full   = hold_valid && q_full;
  assign load   = push && !full;
  assign q_push = hold_valid;
  assign q_cmd  = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load) begin
      hold_valid <= 1'b1;
    end else if (!q_full) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= classified;
    end
  end

endmodule

FILE: design/bmch_back.sv
// Execution stage: tick scheduling, sample accumulation, trimmed mean, scaling and hysteresis.
module bmch_back import bmch_pkg::*; #(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg,
  input  cmd_t    head,
  input  logic    head_empty,
  output logic    head_pop,
  output result_t res,
  output logic    res_push,
  input  logic    res_full
);

  localparam int IDX_W     = $clog2(SAMPLE_COUNT + 1);
  localparam int SUM_W     = ADC_BITS + $clog2(SAMPLE_COUNT + 1);
  localparam int DIVISOR   = SAMPLE_COUNT - TRIM_COUNT;
  localparam int DIV_L     = $clog2(DIVISOR);
  localparam int DIV_SHIFT = SUM_W + DIV_L;
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  // Rounded-up reciprocal: exact quotient for every numerator below 2**SUM_W
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam logic [ADC_BITS-1:0] ADC_ONES = '1;

  // Configuration
  logic [CALX_W-1:0] cal_x10;
  logic [CFG_W-1:0]  th_lower;
  logic [CFG_W-1:0]  th_upper;
  logic [CFG_W-1:0]  th_maintain;
  logic [CFG_W-1:0]  th_disable;
  logic [CFG_W-1:0]  check_interval;
  logic [CFG_W-1:0]  expected_min;
  logic [CFG_W-1:0]  expected_max;

  // Measurement state
  logic [VOLT_W-1:0]   last_voltage;
  logic [TICK_W-1:0]   last_tick;
  logic                charge_off;
  logic                active;
  logic [IDX_W-1:0]    sample_index;
  logic [SUM_W-1:0]    sample_sum;
  logic [ADC_BITS-1:0] low0, low1, high0, high1;

  // Finishing pipeline
  logic [3:0]          fin_stage;
  logic [SUM_W-1:0]    trimmed;
  logic [PROD_W-1:0]   quot;
  logic [SCALED_W-1:0] scaled;

  logic                fin_busy;
  logic                fin_done;
  logic                head_is_tick;
  logic                tick_take;
  logic                samp_take;
  logic [TICK_W-1:0]   now;
  logic [ADC_BITS-1:0] x;
  logic [TICK_W-1:0]   elapsed;
  logic                due;
  logic                accumulate;
  logic                last_sample;
  logic [ADC_BITS-1:0] avg;
  logic [VOLT_W-1:0]   new_voltage;
  logic                charge_next;
  logic [VOLT_W-1:0]   rv;
  logic                rc;

  assign fin_busy     = |fin_stage;
  assign fin_done     = fin_stage[3] && !res_full;
  assign head_is_tick = (head.op == OP_TICK);
  assign head_pop     = !head_empty && !fin_busy && (!head_is_tick || !res_full);
  assign tick_take    = head_pop && head_is_tick;
  assign samp_take    = head_pop && !head_is_tick;
  assign now          = head.arg;
  assign x            = head.arg[ADC_BITS-1:0];
  assign elapsed      = now - last_tick;

  assign due = !active &&
               ((last_voltage >= th_maintain) || (last_tick == '0) ||
                (elapsed > TICK_W'(check_interval)));

  assign accumulate  = samp_take && active && (sample_index != '0);
  assign last_sample = accumulate && (sample_index >= IDX_W'(SAMPLE_COUNT));

  assign avg         = quot[DIV_SHIFT +: ADC_BITS];
  assign new_voltage = scaled[VOLT_SHIFT +: VOLT_W];

  always_comb begin
    if (new_voltage < th_lower) begin
      charge_next = 1'b0;
    end else if (new_voltage > th_upper) begin
      charge_next = 1'b1;
    end else begin
      charge_next = charge_off;
    end
  end

  // Result: finishing measurement reports the new voltage, a tick the stored one
  always_comb begin
    rv                 = fin_stage[3] ? new_voltage : last_voltage;
    rc                 = fin_stage[3] ? charge_next : charge_off;
    res.sample_request = fin_stage[3] ? 1'b0 : due;
    res.voltage        = rv;
    res.out_of_range   = (rv < expected_min) || (rv > expected_max);
    res.charge_disable = rc;
    res.maintain       = (rv >= th_maintain);
    res.load_disable   = (rv < th_disable);
  end

  assign res_push = tick_take || fin_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_x10        <= CAL_X10_RST;
      th_lower       <= LOWER_RST;
      th_upper       <= UPPER_RST;
      th_maintain    <= MAINTAIN_RST;
      th_disable     <= DISABLE_RST;
      check_interval <= INTERVAL_RST;
      expected_min   <= EMIN_RST;
      expected_max   <= EMAX_RST;
      last_voltage   <= '0;
      last_tick      <= '0;
      charge_off     <= 1'b0;
      active         <= 1'b0;
      sample_index   <= '0;
      sample_sum     <= '0;
      low0           <= ADC_ONES;
      low1           <= ADC_ONES;
      high0          <= '0;
      high1          <= '0;
      fin_stage      <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_CALIBRATION:        cal_x10 <= CALX_W'(cfg.data) * CALX_W'(CAL_SCALE);
          REG_THRESHOLD_LOWER:    th_lower       <= cfg.data;
          REG_THRESHOLD_UPPER:    th_upper       <= cfg.data;
          REG_THRESHOLD_MAINTAIN: th_maintain    <= cfg.data;
          REG_THRESHOLD_DISABLE:  th_disable     <= cfg.data;
          REG_CHECK_INTERVAL:     check_interval <= cfg.data;
          REG_EXPECTED_MIN:       expected_min   <= cfg.data;
          REG_EXPECTED_MAX:       expected_max   <= cfg.data;
          default: ;
        endcase
      end

      if (tick_take && due) begin
        last_tick    <= now;
        active       <= 1'b1;
        sample_index <= '0;
        sample_sum   <= '0;
        low0         <= ADC_ONES;
        low1         <= ADC_ONES;
        high0        <= '0;
        high1        <= '0;
      end

      if (samp_take && active && (sample_index == '0)) begin
        sample_index <= IDX_W'(1);
      end

      if (accumulate) begin
        sample_sum <= sample_sum + SUM_W'(x);
        if (x < low0) begin
          low1 <= low0;
          low0 <= x;
        end else if (x < low1) begin
          low1 <= x;
        end
        if (x > high0) begin
          high1 <= high0;
          high0 <= x;
        end else if (x > high1) begin
          high1 <= x;
        end
        if (last_sample) begin
          active       <= 1'b0;
          sample_index <= '0;
        end else begin
          sample_index <= sample_index + IDX_W'(1);
        end
      end

      // Hold the last stage while the result queue is full
      if (!fin_stage[3] || !res_full) begin
        fin_stage <= {fin_stage[2:0], last_sample};
      end

      // Accumulators are read into the trim stage, then cleared
      if (fin_stage[0]) begin
        sample_sum <= '0;
        low0       <= ADC_ONES;
        low1       <= ADC_ONES;
        high0      <= '0;
        high1      <= '0;
      end

      if (fin_done) begin
        last_voltage <= new_voltage;
        charge_off   <= charge_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_stage[0]) begin
      trimmed <= sample_sum - SUM_W'(low0) - SUM_W'(low1) - SUM_W'(high0) - SUM_W'(high1);
    end
    if (fin_stage[1]) begin
      quot <= PROD_W'(trimmed) * PROD_W'(RECIP);
    end
    if (fin_stage[2]) begin
      scaled <= SCALED_W'(avg) * SCALED_W'(cal_x10);
    end
  end

  a_fin_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(fin_stage)) else $error("finish pipeline holds more than one measurement");

  a_no_pop_finishing: assert property (@(posedge clk) disable iff (rst)
    fin_busy |-> !head_pop) else $error("command taken while a measurement finishes");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full) else $error("result pushed into a full queue");

  a_idle_when_finishing: assert property (@(posedge clk) disable iff (rst)
    fin_busy |-> !active) else $error("sampling still active during finish");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    sample_index <= IDX_W'(SAMPLE_COUNT)) else $error("sample index past the sample count");

endmodule

FILE: design/battery_monitor_charge_hysteresis_unit.sv
// Top level of the battery monitor charge hysteresis unit.
// Items enter through a queue-style push/full port: a tick (req_type 0) carries
// the tick counter and always produces one result beat, with sample_request set
// when a measurement is due; a sample (req_type 1) is accumulated while a
// measurement runs. The first sample after a request is dropped, the next
// SAMPLE_COUNT are summed while the two lowest and two highest are tracked, and
// the sample that completes the set produces one result beat with the new
// voltage and flags. Results leave through a pop/empty port. Throughput is one
// item per clock unless something stalls: the front register, the command queue
// and the back stage each take a beat a cycle. A completing sample holds the
// back stage through its finishing steps (trim subtraction, reciprocal multiply
// for the trimmed mean, calibration multiply, hysteresis update); items meanwhile
// collect in the command queue. An item passes the front register, command
// queue and result queue on its way out. Configuration writes are always taken
// (cfg_ready is high) and must only happen while the block is idle.
module battery_monitor_charge_hysteresis_unit import bmch_pkg::*; #(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // item side
  input  logic                 push,
  input  item_t                item,
  output logic                 full,
  // result side
  input  logic                 pop,
  output result_t              result,
  output logic                 empty,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t    front_cmd;
  logic    front_push;
  logic    cmdq_full;
  cmd_t    head;
  logic    head_empty;
  logic    head_pop;
  result_t back_res;
  logic    back_push;
  logic    resq_full;
  cfg_wr_t cfg_wr;

  // Register writes land in the back stage in the cycle they are accepted
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // Classify each beat and stage it
  bmch_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_push (front_push),
    .q_cmd  (front_cmd),
    .q_full (cmdq_full)
  );

  // Decouple the front from the back so either can stall alone
  bmch_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_cmd),
    .full  (cmdq_full),
    .pop   (head_pop),
    .rdata (head),
    .empty (head_empty)
  );

  // Execute ticks and samples, finish measurements
  bmch_back #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_wr),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .res        (back_res),
    .res_push   (back_push),
    .res_full   (resq_full)
  );

  // Hold finished results until the consumer pops them
  bmch_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (back_push),
    .wdata (back_res),
    .full  (resq_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

FILE: verif/tb.sv
// Self-checking bench for the battery monitor charge hysteresis unit.
`timescale 1ns / 1ps

module tb import bmch_pkg::*;;

  // Pause after the last expected beat before a register write or the final verdict:
  // covers the front register, the command queue and the completion stall.
  localparam int SETTLE_CYC  = 24;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int STALL_LIMIT = 3000;
  localparam int PHASES      = 8;
  // Items per random phase that the block actually consumes.
  localparam int PHASE_ITEMS = 240;
  localparam int MAX_PRINT   = 60;

  // Directed stimulus row: a register write, or an item repeated reps times.
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    item_t                itm;
    logic [4:0]           reps;
    logic                 typed;
    result_t              want;
  } step_t;

  logic                 clk;
  logic                 rst;
  logic                 push;
  item_t                item;
  logic                 full;
  logic                 pop;
  result_t              result;
  logic                 empty;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  battery_monitor_charge_hysteresis_unit dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .pop       (pop),
    .result    (result),
    .empty     (empty),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the monitor: registers, last reading, hysteresis and the sample window.
  logic [CFG_W-1:0]    reg_file [8];
  logic [VOLT_W-1:0]   volt_now;
  logic [TICK_W-1:0]   stamp;
  logic                chg_off;
  logic                busy;
  logic [4:0]          n_seen;
  logic [13:0]         run_sum;
  logic [ADC_BITS-1:0] low2 [2];
  logic [ADC_BITS-1:0] high2 [2];

  // Status beats the block still owes us, oldest first.
  result_t expected_reports [$];

  int err_cnt;
  int used_items;
  int send_idle;
  int recv_stall;
  logic [TICK_W-1:0] tick_now;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Drop the window back to empty: no samples, min trackers high, max trackers low.
  function automatic void clear_window();
    n_seen   = '0;
    run_sum  = '0;
    low2[0]  = '1;
    low2[1]  = '1;
    high2[0] = '0;
    high2[1] = '0;
  endfunction

  // Build a status beat from the reading as it stands now.
  function automatic result_t report_flags(input logic req);
    result_t r;
    r.sample_request = req;
    r.voltage        = volt_now;
    r.out_of_range   = (volt_now < reg_file[REG_EXPECTED_MIN]) ||
                       (volt_now > reg_file[REG_EXPECTED_MAX]);
    r.charge_disable = chg_off;
    r.maintain       = (volt_now >= reg_file[REG_THRESHOLD_MAINTAIN]);
    r.load_disable   = (volt_now < reg_file[REG_THRESHOLD_DISABLE]);
    return r;
  endfunction

  // Advance the shadow monitor by one accepted item. has_rep tells whether it owes a beat;
  // used is low for a sample that arrives with no measurement running.
  function automatic void monitor_step(input item_t it, output logic has_rep,
                                       output result_t rep, output logic used);
    logic [TICK_W-1:0]   gap;
    logic [ADC_BITS-1:0] x;
    logic [13:0]         trimmed;
    int unsigned         avg;
    int unsigned         scaled;
    logic                req;
    has_rep = 1'b0;
    rep     = '0;
    used    = 1'b1;
    req     = 1'b0;
    if (it.req_type == OP_TICK) begin
      // Modulo-2^32 distance since the recorded tick; a recorded zero forces a new reading.
      gap = it.tick_count - stamp;
      if (!busy && ((volt_now >= reg_file[REG_THRESHOLD_MAINTAIN]) || (stamp == '0) ||
                    (gap > TICK_W'(reg_file[REG_CHECK_INTERVAL])))) begin
        stamp = it.tick_count;
        busy  = 1'b1;
        clear_window();
        req   = 1'b1;
      end
      rep     = report_flags(req);
      has_rep = 1'b1;
    end else if (!busy) begin
      used = 1'b0;
    end else if (n_seen == '0) begin
      // Throw away the first conversion after the request.
      n_seen = 5'd1;
    end else begin
      x       = it.adc_sample;
      run_sum = run_sum + 14'(x);
      if (x < low2[0]) begin
        low2[1] = low2[0];
        low2[0] = x;
      end else if (x < low2[1]) begin
        low2[1] = x;
      end
      if (x > high2[0]) begin
        high2[1] = high2[0];
        high2[0] = x;
      end else if (x > high2[1]) begin
        high2[1] = x;
      end
      if (n_seen >= 5'(SAMPLE_COUNT_DEF)) begin
        // Trimmed mean, calibration scale, keep the low byte, then hysteresis.
        trimmed  = run_sum - low2[0] - low2[1] - high2[0] - high2[1];
        avg      = trimmed / (SAMPLE_COUNT_DEF - TRIM_COUNT);
        scaled   = avg * reg_file[REG_CALIBRATION] * CAL_SCALE;
        volt_now = VOLT_W'(scaled >> VOLT_SHIFT);
        if (volt_now < reg_file[REG_THRESHOLD_LOWER]) begin
          chg_off = 1'b0;
        end else if (volt_now > reg_file[REG_THRESHOLD_UPPER]) begin
          chg_off = 1'b1;
        end
        busy = 1'b0;
        clear_window();
        rep     = report_flags(1'b0);
        has_rep = 1'b1;
      end else begin
        n_seen = n_seen + 5'd1;
      end
    end
  endfunction

  task automatic report_bad(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= MAX_PRINT) begin
      $display("ERROR at %0t ns: %s got %0d want %0d", $time, what, got, want);
    end
  endtask

  function automatic result_t flags_of(input logic req, input logic [VOLT_W-1:0] v,
                                       input logic oor, input logic chg,
                                       input logic mnt, input logic ld);
    result_t r;
    r.sample_request = req;
    r.voltage        = v;
    r.out_of_range   = oor;
    r.charge_disable = chg;
    r.maintain       = mnt;
    r.load_disable   = ld;
    return r;
  endfunction

  function automatic step_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    step_t s;
    s         = '0;
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic step_t item_row(input logic kind, input logic [TICK_W-1:0] cnt,
                                     input logic [ADC_BITS-1:0] smp, input int reps,
                                     input logic typed, input result_t want);
    step_t s;
    s                = '0;
    s.itm.req_type   = kind;
    s.itm.tick_count = cnt;
    s.itm.adc_sample = smp;
    s.reps           = 5'(reps);
    s.typed          = typed;
    s.want           = want;
    return s;
  endfunction

  // Hold the config channel until the write beat is taken, then mirror it.
  // Valid is left high; the caller drops it once the batch is done.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_file[idx] = val;
  endtask

  // Drop both request lines, wait out every owed beat, then let in-flight samples drain.
  task automatic settle();
    push      <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Offer one item after a random gap; once the push beat lands, predict what it owes.
  // A typed row substitutes its hand-written beat for the prediction.
  task automatic send_item(input item_t it, input logic typed, input result_t want);
    logic    has;
    logic    used;
    result_t rep;
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    monitor_step(it, has, rep, used);
    if (has) begin
      expected_reports.push_back(typed ? want : rep);
    end
    if (used) begin
      used_items++;
    end
  endtask

  task automatic send_tick(input logic [TICK_W-1:0] cnt);
    item_t it;
    it.req_type   = OP_TICK;
    it.tick_count = cnt;
    it.adc_sample = ADC_BITS'($urandom);
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_sample(input logic [ADC_BITS-1:0] v);
    item_t it;
    it.req_type   = OP_SAMPLE;
    it.tick_count = $urandom;
    it.adc_sample = v;
    send_item(it, 1'b0, '0);
  endtask

  // Conversion scattered around a level, with the odd rail hit or wild value.
  function automatic logic [ADC_BITS-1:0] near(input int center, input int spread);
    int v;
    case ($urandom_range(0, 19))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return ADC_BITS'($urandom);
      end
      default: begin
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return ADC_BITS'(v);
      end
    endcase
  endfunction

  // Load every register for one phase: all clear, all set, or a random mix.
  task automatic program_phase(input int p);
    logic [CFG_W-1:0] cal, lower, upper, mnt, dis, ivl, emin, emax;
    if (p == 1) begin
      {cal, lower, upper, mnt, dis, ivl, emin, emax} = '0;
    end else if (p == 2) begin
      {cal, lower, upper, mnt, dis, ivl, emin, emax} = '1;
    end else begin
      cal   = CFG_W'($urandom_range(0, 255));
      lower = CFG_W'($urandom_range(0, 255));
      upper = CFG_W'($urandom_range(0, 255));
      mnt   = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 255))
                                          : CFG_W'($urandom_range(200, 255));
      dis   = CFG_W'($urandom_range(0, 255));
      ivl   = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 255))
                                          : CFG_W'($urandom_range(0, 12));
      emin  = CFG_W'($urandom_range(0, 150));
      emax  = CFG_W'(int'(emin) + int'($urandom_range(0, 255 - int'(emin))));
    end
    write_reg(REG_CALIBRATION, cal);
    write_reg(REG_THRESHOLD_LOWER, lower);
    write_reg(REG_THRESHOLD_UPPER, upper);
    write_reg(REG_THRESHOLD_MAINTAIN, mnt);
    write_reg(REG_THRESHOLD_DISABLE, dis);
    write_reg(REG_CHECK_INTERVAL, ivl);
    write_reg(REG_EXPECTED_MIN, emin);
    write_reg(REG_EXPECTED_MAX, emax);
    cfg_valid <= 1'b0;
  endtask

  // Result side: check each popped beat against the oldest owed one, then pick the next pop.
  initial begin
    result_t want;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (expected_reports.size() == 0) begin
          report_bad("result beat with nothing owed", int'(result), 0);
        end else begin
          want = expected_reports.pop_front();
          if (result.sample_request !== want.sample_request)
            report_bad("sample_request", result.sample_request, want.sample_request);
          if (result.voltage !== want.voltage)
            report_bad("voltage", result.voltage, want.voltage);
          if (result.out_of_range !== want.out_of_range)
            report_bad("out_of_range", result.out_of_range, want.out_of_range);
          if (result.charge_disable !== want.charge_disable)
            report_bad("charge_disable", result.charge_disable, want.charge_disable);
          if (result.maintain !== want.maintain)
            report_bad("maintain", result.maintain, want.maintain);
          if (result.load_disable !== want.load_disable)
            report_bad("load_disable", result.load_disable, want.load_disable);
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // Watchdog: end the run when no beat of any kind is accepted for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("battery_monitor_charge_hysteresis_unit: mismatch");
    $finish;
  end

  initial begin
    step_t rows [$];
    step_t s;
    logic  prev_cfg;
    int    p, k, pick, center, spread, goal, burst;

    rst       <= 1'b1;
    push      <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    err_cnt    = 0;
    used_items = 0;
    send_idle  = 0;
    recv_stall = 0;
    tick_now   = '0;
    prev_cfg   = 1'b0;

    // Mirror the reset state of the block.
    reg_file[REG_CALIBRATION]        = '0;
    reg_file[REG_THRESHOLD_LOWER]    = LOWER_RST;
    reg_file[REG_THRESHOLD_UPPER]    = UPPER_RST;
    reg_file[REG_THRESHOLD_MAINTAIN] = MAINTAIN_RST;
    reg_file[REG_THRESHOLD_DISABLE]  = DISABLE_RST;
    reg_file[REG_CHECK_INTERVAL]     = INTERVAL_RST;
    reg_file[REG_EXPECTED_MIN]       = EMIN_RST;
    reg_file[REG_EXPECTED_MAX]       = EMAX_RST;
    volt_now = '0;
    stamp    = '0;
    chg_off  = 1'b0;
    busy     = 1'b0;
    clear_window();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed rows. Full gain and a low upper threshold, so rail samples overflow the byte
    // and latch the charge disable.
    rows.push_back(cfg_row(REG_CALIBRATION, 8'd255));
    rows.push_back(cfg_row(REG_THRESHOLD_UPPER, 8'd40));
    // Sample with no measurement running: ignored, owes nothing.
    rows.push_back(item_row(OP_SAMPLE, '0, 10'h3FF, 1, 1'b0, '0));
    // Nothing recorded yet, so a tick of zero is due and is itself recorded as zero.
    rows.push_back(item_row(OP_TICK, 32'h0000_0000, '0, 1, 1'b1,
                            flags_of(1'b1, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0)));
    // Tick while sampling: no restart, flags unchanged.
    rows.push_back(item_row(OP_TICK, 32'hFFFF_FFFF, '0, 1, 1'b1,
                            flags_of(1'b0, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0)));
    // Discarded conversion, then fifteen at the top rail: 1023*2550 >> 13 wraps to 62.
    rows.push_back(item_row(OP_SAMPLE, '0, 10'h000, 1, 1'b0, '0));
    rows.push_back(item_row(OP_SAMPLE, '0, 10'h3FF, 15, 1'b1,
                            flags_of(1'b0, 8'd62, 1'b1, 1'b1, 1'b0, 1'b0)));
    // Recorded tick is still zero, so a near tick is due again.
    rows.push_back(item_row(OP_TICK, 32'd3, '0, 1, 1'b1,
                            flags_of(1'b1, 8'd62, 1'b1, 1'b1, 1'b0, 1'b0)));
    // Mixed window: both trimmed minima at zero, both maxima at the same level.
    rows.push_back(item_row(OP_SAMPLE, '0, 10'h000, 8, 1'b0, '0));
    rows.push_back(item_row(OP_SAMPLE, '0, 10'h2AA, 8, 1'b0, '0));
    rows.push_back(item_row(OP_TICK, 32'd4, '0, 1, 1'b0, '0));
    // Maintain threshold at zero: every idle tick starts a reading.
    rows.push_back(cfg_row(REG_THRESHOLD_MAINTAIN, 8'd0));
    rows.push_back(item_row(OP_TICK, 32'd5, '0, 1, 1'b0, '0));

    foreach (rows[i]) begin
      s = rows[i];
      if (s.is_cfg) begin
        settle();
        write_reg(s.reg_idx, s.reg_val);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_valid <= 1'b0;
        prev_cfg = 1'b0;
        for (k = 0; k < int'(s.reps); k++) send_item(s.itm, s.typed, s.want);
      end
    end
    tick_now = 32'd5;

    // Random phases: rotate through no idling, sender gaps, receiver stalls and both.
    for (p = 0; p < PHASES; p++) begin
      settle();
      program_phase(p);
      case (p % 4)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle  = 55;
          recv_stall = 0;
        end
        2: begin
          send_idle  = 0;
          recv_stall = 55;
        end
        default: begin
          send_idle  = 34;
          recv_stall = 34;
        end
      endcase
      goal = used_items + PHASE_ITEMS;
      while (used_items < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // Full measurement: a due tick, then the discarded conversion and the window,
          // with the odd tick landing mid-window.
          tick_now = tick_now + TICK_W'(reg_file[REG_CHECK_INTERVAL]) +
                     TICK_W'($urandom_range(1, 5));
          if ($urandom_range(0, 19) == 0) tick_now = '0;
          send_tick(tick_now);
          center = $urandom_range(0, 1023);
          spread = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
          for (k = 0; k <= SAMPLE_COUNT_DEF; k++) begin
            if ($urandom_range(0, 99) < 6) send_tick(tick_now + TICK_W'($urandom_range(0, 3)));
            send_sample(near(center, spread));
          end
        end else if (pick < 82) begin
          // Lone tick: either just past the last one or anywhere on the 32-bit wheel.
          if ($urandom_range(0, 1) == 1) begin
            tick_now = tick_now + TICK_W'($urandom_range(0, 3));
          end else begin
            tick_now = $urandom;
          end
          send_tick(tick_now);
        end else if (pick < 92) begin
          send_sample(ADC_BITS'($urandom));
        end else begin
          // Broken sequence: request readings, then hand over only part of a window.
          tick_now = tick_now + TICK_W'(reg_file[REG_CHECK_INTERVAL]) + TICK_W'(1);
          send_tick(tick_now);
          burst  = $urandom_range(1, 12);
          center = $urandom_range(0, 1023);
          for (k = 0; k < burst; k++) send_sample(near(center, 30));
        end
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("battery_monitor_charge_hysteresis_unit: match");
    end else begin
      $display("battery_monitor_charge_hysteresis_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: battery_monitor_charge_hysteresis_unit.f
design/bmch_pkg.sv
design/bmch_fifo.sv
design/bmch_front.sv
design/bmch_back.sv
design/battery_monitor_charge_hysteresis_unit.sv
verif/tb.sv
